FILE: rtl/ema_pulse_trigger_detector_assert.svh
// Assertion macros for the checker file of the pulse trigger detector.
// No dependencies; included by bare file name.
`ifndef EMA_PULSE_TRIGGER_DETECTOR_ASSERT_SVH
`define EMA_PULSE_TRIGGER_DETECTOR_ASSERT_SVH

// Checked only outside reset.
`define EPTD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// Checked at every edge, reset included.
`define EPTD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

FILE: rtl/ema_ptd_pkg.sv
// Types and constants of the EMA pulse trigger detector.
// No dependencies; used by the core and the top level.
`timescale 1ns / 1ps

package ema_ptd_pkg;

	localparam int SAMPLE_W = 8;
	localparam int WEIGHT_W = 9;
	localparam int ACC_W    = 16;
	localparam int RUN_W    = 9;
	localparam int POST_W   = 16;
	localparam int PCNT_W   = 17;
	localparam int CIDX_W   = 2;
	localparam int CDATA_W  = 16;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 16;

	// weight of 1.0 in 256ths
	localparam logic [WEIGHT_W-1:0] ONE_Q8 = 9'd256;

	localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 9'd179;
	localparam logic [7:0]          RST_THRESHOLD = 8'd150;
	localparam logic [7:0]          RST_HOLD      = 8'd10;
	localparam logic [POST_W-1:0]   RST_POST      = 16'd250;

	typedef enum logic [CIDX_W-1:0] {
		CFG_WEIGHT    = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_HOLD      = 2'd2,
		CFG_POST      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [7:0]          threshold;
		logic [7:0]          hold_max;
		logic [POST_W-1:0]   post_max;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0]  filter_acc;
		logic [RUN_W-1:0]  high_run;
		logic              armed;
		logic [PCNT_W-1:0] post_count;
	} state_t;

	typedef struct packed {
		logic [7:0] smoothed;
		logic       pulse_active;
		logic       send_event;
	} result_t;

endpackage

FILE: rtl/ema_ptd_core.sv
// One-sample update of the EMA filter and the arm/post-count trigger logic.
// Depends on ema_ptd_pkg; combinational, state held by the top level.
`timescale 1ns / 1ps

module ema_ptd_core (
	input  logic [ema_ptd_pkg::SAMPLE_W-1:0] sample,
	input  ema_ptd_pkg::cfg_t                cfg,
	input  ema_ptd_pkg::state_t              state,
	output ema_ptd_pkg::state_t              state_nx,
	output ema_ptd_pkg::result_t             result
);

	logic [ema_ptd_pkg::WEIGHT_W-1:0] w_sat;
	logic [ema_ptd_pkg::WEIGHT_W-1:0] w_inv;
	logic [16:0]                      prod_new;
	logic [24:0]                      prod_old;
	logic [16:0]                      acc_sum;
	logic [ema_ptd_pkg::ACC_W-1:0]    acc_nx;
	logic [7:0]                       level;
	logic                             is_high;
	logic                             armed_mid;
	logic                             send;

	// weights above 1.0 clamp to 1.0
	assign w_sat = (cfg.weight > ema_ptd_pkg::ONE_Q8) ? ema_ptd_pkg::ONE_Q8 : cfg.weight;
	assign w_inv = ema_ptd_pkg::ONE_Q8 - w_sat;

	// (w*(s<<8) + inv*acc) >> 8 == w*s + (inv*acc >> 8): low byte of first term is zero
	assign prod_new = w_sat * sample;
	assign prod_old = w_inv * state.filter_acc;
	assign acc_sum  = prod_new + {1'b0, prod_old[23:8]};
	assign acc_nx   = acc_sum[ema_ptd_pkg::ACC_W-1:0];
	assign level    = acc_nx[15:8];
	assign is_high  = (level >= cfg.threshold);

	always_comb begin
		state_nx            = state;
		state_nx.filter_acc = acc_nx;
		send                = 1'b0;

		if (!state.armed) begin
			if (is_high) begin
				if (state.high_run <= {1'b0, cfg.hold_max}) begin
					state_nx.high_run = state.high_run + 1'b1;
				end else begin
					state_nx.high_run = '0;
					state_nx.armed    = 1'b1;
				end
			end else begin
				state_nx.high_run = '0;
			end
		end
		armed_mid = state_nx.armed;

		// post count also runs on the step that arms
		if (armed_mid) begin
			if (state.post_count <= {1'b0, cfg.post_max}) begin
				state_nx.post_count = state.post_count + 1'b1;
			end else begin
				state_nx.post_count = '0;
				state_nx.armed      = 1'b0;
				send                = 1'b1;
			end
		end
	end

	assign result.smoothed     = level;
	assign result.pulse_active = state_nx.armed;
	assign result.send_event   = send;

endmodule

FILE: rtl/ema_pulse_trigger_detector.sv
// EMA pulse trigger detector: sample register, filter/trigger update, result register.
// Depends on ema_ptd_pkg and ema_ptd_core.
`timescale 1ns / 1ps

// Takes one 8-bit sample per clock while the master side does not stall and returns one
// result per sample, in order: the integer part of the smoothed level, the armed flag and
// a one-item send flag. A sample is registered in the sample register, run through the
// filter and trigger update once the result register is free, and its result registered
// in the result register on the master side. The rate is set by the filter feedback (two
// small multipliers and an add). An empty sample register takes a sample while a result
// waits; master-side stalls hold a full sample register. cfg_ready is always high; the
// user must write registers only while no sample is in flight, which the block itself
// does not enforce.

module ema_pulse_trigger_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] smoothed, [8] pulse_active, [9] send_event, zero above
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ema_ptd_pkg::cfg_t    cfg_q;
	ema_ptd_pkg::state_t  state_q;
	ema_ptd_pkg::state_t  state_nx;
	ema_ptd_pkg::result_t result;

	logic       valid_s1;
	logic [7:0] sample_s1;
	logic       out_free;
	logic       advance;
	logic       m_tvalid_q;
	logic [9:0] m_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight    <= ema_ptd_pkg::RST_WEIGHT;
			cfg_q.threshold <= ema_ptd_pkg::RST_THRESHOLD;
			cfg_q.hold_max  <= ema_ptd_pkg::RST_HOLD;
			cfg_q.post_max  <= ema_ptd_pkg::RST_POST;
		end else if (cfg_valid && cfg_ready) begin
			case (ema_ptd_pkg::cfg_idx_t'(cfg_index))
				ema_ptd_pkg::CFG_WEIGHT:    cfg_q.weight    <= cfg_data[8:0];
				ema_ptd_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_data[7:0];
				ema_ptd_pkg::CFG_HOLD:      cfg_q.hold_max  <= cfg_data[7:0];
				ema_ptd_pkg::CFG_POST:      cfg_q.post_max  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata;
		end
	end

	ema_ptd_core u_core (
		.sample   (sample_s1),
		.cfg      (cfg_q),
		.state    (state_q),
		.state_nx (state_nx),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			state_q    <= state_nx;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {result.send_event, result.pulse_active, result.smoothed};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, m_data_q};

endmodule

FILE: rtl/ema_ptd_checker.sv
// Port-level checks for the EMA pulse trigger detector, bound to the top level.
// Depends on ema_pulse_trigger_detector_assert.svh.
`timescale 1ns / 1ps
`include "ema_pulse_trigger_detector_assert.svh"

module ema_ptd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	`EPTD_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	// the send step disarms
	`EPTD_ASSERT(a_send_disarms, clk, arst_n, m_tvalid && m_tdata[9] |-> !m_tdata[8])
	// padding above the flags stays zero
	`EPTD_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[15:10] == 6'd0)
	// no result during reset
	`EPTD_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !m_tvalid)

endmodule

bind ema_pulse_trigger_detector ema_ptd_checker u_ema_ptd_checker (.*);
